>>> hw/rtl/prgal_pkg.sv
// Shared types and constants for the pump run guard with adaptive limit.
// Holds field widths, action and status codes, and the beat layouts.
// No dependencies.
package prgal_pkg;

   // Field widths
   localparam int TICK_BITS   = 16;
   localparam int SAMPLE_BITS = 10;
   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 3;
   localparam int CSR_IDX_BITS = 2;

   // Stream widths, padded to whole bytes
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;

   // Rounding offset for the sixteenth cut, shifts for the adaptation steps
   localparam int CUT_ROUND = 15;
   localparam int CUT_SHIFT = 4;
   localparam int GROW_SHIFT = 5;

   // Action codes
   localparam logic [ACTION_BITS-1:0] ACT_ACTIVATE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_TICK     = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR    = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_NONE     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_STARTED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FINISHED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_LOW      = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_SHORT    = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_BUSY     = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVEL_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVEL_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUR_FLOOR  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DUR_CEIL   = 2'd3;

   // Reset values of the configuration registers
   localparam logic [SAMPLE_BITS-1:0] LEVEL_LOW_RST  = 10'd200;
   localparam logic [SAMPLE_BITS-1:0] LEVEL_HIGH_RST = 10'd900;
   localparam logic [TICK_BITS-1:0]   DUR_FLOOR_RST  = 16'd1000;
   localparam logic [TICK_BITS-1:0]   DUR_CEIL_RST   = 16'd60000;

   // One input beat after unpacking
   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [TICK_BITS-1:0]   requested_duration;
      logic [SAMPLE_BITS-1:0] level_sample;
      logic                   overflow_pin;
   } req_item_type;

   // One result beat before packing
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   pump_on;
      logic                   active_mark;
      logic                   overflow_flag;
      logic [TICK_BITS-1:0]   run_limit;
      logic [TICK_BITS-1:0]   last_run;
   } rsp_item_type;

endpackage

>>> hw/rtl/pump_run_guard_adaptive_limit_core.sv
// Pump run guard with adaptive run limit: top level.
// An accepted beat passes through the input register, then the result register.
// Throughput: one beat per cycle; req_tready drops only while the result
// register is full and rsp_tready is low. Reset (synchronous, active high)
// stops the pump, clears all marks and counters, loads the configuration
// reset values and sets the run limit to the ceiling reset value.
// Depends on prgal_pkg.
module pump_run_guard_adaptive_limit_core
   import prgal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [15:0] requested_duration, [25:16] level_sample, [26] overflow_pin
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] action
   input  logic [ACTION_BITS-1:0]   req_tuser,
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] pump_on, [1] active_mark, [2] overflow_flag, [18:3] run_limit,
   // [34:19] last_run
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [2:0] status
   output logic [STATUS_BITS-1:0]   rsp_tuser,
   // configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [TICK_BITS-1:0]     csr_data
);

   // Configuration registers
   logic [SAMPLE_BITS-1:0] level_low_ff;
   logic [SAMPLE_BITS-1:0] level_high_ff;
   logic [TICK_BITS-1:0]   dur_floor_ff;
   logic [TICK_BITS-1:0]   dur_ceil_ff;

   // Run state
   logic                 running_ff, running_in;
   logic                 active_ff, active_in;
   logic                 ovf_seen_ff, ovf_seen_in;
   logic                 armed_ff, armed_in;
   logic [TICK_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TICK_BITS-1:0] target_ff, target_in;
   logic [TICK_BITS-1:0] prev_run_ff, prev_run_in;
   logic [TICK_BITS-1:0] limit_ff, limit_in;

   // Pipeline registers
   logic         in_valid_ff;
   req_item_type item_ff;
   logic         out_valid_ff;
   rsp_item_type out_ff;
   rsp_item_type out_in;

   logic advance;

   // Move the held beat into the result register when it is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         level_low_ff  <= LEVEL_LOW_RST;
         level_high_ff <= LEVEL_HIGH_RST;
         dur_floor_ff  <= DUR_FLOOR_RST;
         dur_ceil_ff   <= DUR_CEIL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEVEL_LOW:  level_low_ff  <= csr_data[SAMPLE_BITS-1:0];
            CSR_LEVEL_HIGH: level_high_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_DUR_FLOOR:  dur_floor_ff  <= csr_data;
            CSR_DUR_CEIL:   dur_ceil_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.action             <= req_tuser;
         item_ff.requested_duration <= req_tdata[TICK_BITS-1:0];
         item_ff.level_sample       <= req_tdata[TICK_BITS+SAMPLE_BITS-1:TICK_BITS];
         item_ff.overflow_pin       <= req_tdata[TICK_BITS+SAMPLE_BITS];
      end
   end

   // Level classification, adaptation and clamp helpers
   logic [STATUS_BITS-1:0] level_class;
   logic [TICK_BITS:0]     cut_sum;
   logic [TICK_BITS-1:0]   reduced;
   logic [TICK_BITS:0]     grown_sum;
   logic [TICK_BITS-1:0]   grown;
   logic [TICK_BITS-1:0]   adapt_raw;
   logic [TICK_BITS-1:0]   adapt_floor;
   logic [TICK_BITS-1:0]   adapt_clamped;
   logic [TICK_BITS-1:0]   limit_adapted;
   logic [TICK_BITS-1:0]   request_clamped;
   logic [TICK_BITS-1:0]   elapsed_inc;

   always_comb begin
      if (item_ff.level_sample > level_high_ff) begin
         level_class = ST_SHORT;
      end else if (item_ff.level_sample < level_low_ff) begin
         level_class = ST_LOW;
      end else begin
         level_class = ST_NONE;
      end

      // Cut by a rounded-up sixteenth after an overflow
      cut_sum = {1'b0, prev_run_ff} + (TICK_BITS+1)'(CUT_ROUND);
      reduced = prev_run_ff - TICK_BITS'(cut_sum[TICK_BITS:CUT_SHIFT]);

      // Grow by a rounded-down thirty-second, saturating
      grown_sum = {1'b0, limit_ff} + {1'b0, (limit_ff >> GROW_SHIFT)};
      grown     = grown_sum[TICK_BITS] ? {TICK_BITS{1'b1}} : grown_sum[TICK_BITS-1:0];

      adapt_raw     = ovf_seen_ff ? reduced : grown;
      adapt_floor   = (adapt_raw < dur_floor_ff) ? dur_floor_ff : adapt_raw;
      adapt_clamped = (adapt_floor > dur_ceil_ff) ? dur_ceil_ff : adapt_floor;

      if (ovf_seen_ff || (prev_run_ff == limit_ff)) begin
         limit_adapted = adapt_clamped;
      end else begin
         limit_adapted = limit_ff;
      end

      request_clamped = (item_ff.requested_duration > limit_adapted) ?
                        limit_adapted : item_ff.requested_duration;

      elapsed_inc = (elapsed_ff == {TICK_BITS{1'b1}}) ? elapsed_ff :
                    elapsed_ff + TICK_BITS'(1);
   end

   // Step the run state for the held beat
   always_comb begin
      logic [STATUS_BITS-1:0] status;
      status      = ST_NONE;
      running_in  = running_ff;
      active_in   = active_ff;
      ovf_seen_in = ovf_seen_ff;
      armed_in    = armed_ff;
      elapsed_in  = elapsed_ff;
      target_in   = target_ff;
      prev_run_in = prev_run_ff;
      limit_in    = limit_ff;

      case (item_ff.action)
         ACT_ACTIVATE: begin
            if (running_ff) begin
               status = ST_BUSY;
            end else begin
               status = level_class;
               if (level_class == ST_NONE) begin
                  limit_in    = limit_adapted;
                  ovf_seen_in = 1'b0;
                  armed_in    = 1'b1;
                  if (item_ff.overflow_pin) begin
                     ovf_seen_in = 1'b1;
                     armed_in    = 1'b0;
                     status      = ST_OVERFLOW;
                  end else if (request_clamped == '0) begin
                     elapsed_in  = '0;
                     prev_run_in = '0;
                     status      = ST_FINISHED;
                  end else begin
                     active_in  = 1'b1;
                     running_in = 1'b1;
                     elapsed_in = '0;
                     target_in  = request_clamped;
                     status     = ST_STARTED;
                  end
               end
            end
         end
         ACT_TICK: begin
            if (running_ff) begin
               elapsed_in = elapsed_inc;
               if (armed_ff && item_ff.overflow_pin) begin
                  ovf_seen_in = 1'b1;
                  armed_in    = 1'b0;
                  status      = ST_OVERFLOW;
               end else if (level_class != ST_NONE) begin
                  status = level_class;
               end else if (elapsed_inc >= target_ff) begin
                  status = ST_FINISHED;
               end
               // Any reason above ends the run
               if (status != ST_NONE) begin
                  running_in  = 1'b0;
                  active_in   = 1'b0;
                  prev_run_in = elapsed_inc;
               end
            end else if (armed_ff && item_ff.overflow_pin) begin
               ovf_seen_in = 1'b1;
               armed_in    = 1'b0;
            end
         end
         ACT_CLEAR: begin
            active_in = 1'b0;
         end
         default: ;
      endcase

      out_in.status        = status;
      out_in.pump_on       = running_in;
      out_in.active_mark   = active_in;
      out_in.overflow_flag = ovf_seen_in;
      out_in.run_limit     = limit_in;
      out_in.last_run      = prev_run_in;
   end

   // State update, one beat per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         active_ff   <= 1'b0;
         ovf_seen_ff <= 1'b0;
         armed_ff    <= 1'b0;
         elapsed_ff  <= '0;
         target_ff   <= '0;
         prev_run_ff <= '0;
         limit_ff    <= DUR_CEIL_RST;
      end else if (advance) begin
         running_ff  <= running_in;
         active_ff   <= active_in;
         ovf_seen_ff <= ovf_seen_in;
         armed_ff    <= armed_in;
         elapsed_ff  <= elapsed_in;
         target_ff   <= target_in;
         prev_run_ff <= prev_run_in;
         limit_ff    <= limit_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {5'b0, out_ff.last_run, out_ff.run_limit, out_ff.overflow_flag,
                        out_ff.active_mark, out_ff.pump_on};

   // A run in progress always has a nonzero target
   assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (target_ff != '0))
      else $error("run active with zero target length");

   // A run in progress has not yet reached its target
   assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (elapsed_ff < target_ff))
      else $error("run active past its target length");

   // A started result always reports the pump on and the active mark set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_STARTED)) |-> (rsp_tdata[0] && rsp_tdata[1]))
      else $error("started status without pump drive");

endmodule

>>> dv/tb_pump_run_guard_adaptive_limit_core.sv
// Testbench for the pump run guard core: directed rows, an adaptation run, then paced random runs.
// Results are checked beat by beat against a run-state predictor kept in the bench.
// Depends on prgal_pkg and pump_run_guard_adaptive_limit_core.
`timescale 1ns / 100ps

module tb_pump_run_guard_adaptive_limit_core;
   import prgal_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
   localparam int unsigned TICK_MAX    = (1 << TICK_BITS) - 1;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned LOG_LIMIT   = 60;

   typedef struct packed {
      req_item_type beat;
      logic         pinned;
      rsp_item_type want;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [ACTION_BITS-1:0]   req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [TICK_BITS-1:0]     csr_data = '0;

   // Predictor copy of the settings and the run state
   logic [SAMPLE_BITS-1:0] cfg_level_low  = LEVEL_LOW_RST;
   logic [SAMPLE_BITS-1:0] cfg_level_high = LEVEL_HIGH_RST;
   logic [TICK_BITS-1:0]   cfg_floor      = DUR_FLOOR_RST;
   logic [TICK_BITS-1:0]   cfg_ceiling    = DUR_CEIL_RST;
   logic                   pump_running       = 1'b0;
   logic                   pump_active        = 1'b0;
   logic                   pump_overflow_seen = 1'b0;
   logic                   pump_detect_armed  = 1'b0;
   logic [TICK_BITS-1:0]   pump_elapsed  = '0;
   logic [TICK_BITS-1:0]   pump_target   = '0;
   logic [TICK_BITS-1:0]   pump_last_run = '0;
   logic [TICK_BITS-1:0]   pump_limit    = DUR_CEIL_RST;

   rsp_item_type pending_results[$];
   rsp_item_type seen_beat;
   rsp_item_type wanted_beat;
   int unsigned  failure_count = 0;
   int unsigned  stall_cycles  = 0;
   int unsigned  burst_left    = 0;
   bit           pacing_on     = 1'b1;
   int unsigned  ready_mode    = 0;
   int unsigned  ready_left    = 0;

   // Directed rows under the reset settings; pinned rows carry their result
   directed_row_type directed_rows [24] = '{
      '{'{ACT_TICK, 16'd0, 10'd500, 1'b0}, 1'b1,
        '{ST_NONE, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_CLEAR, 16'd0, 10'd500, 1'b0}, 1'b1,
        '{ST_NONE, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_UNUSED, 16'hFFFF, 10'h3FF, 1'b1}, 1'b1,
        '{ST_NONE, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_ACTIVATE, 16'd10, 10'd901, 1'b0}, 1'b1,
        '{ST_SHORT, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_ACTIVATE, 16'd10, 10'd199, 1'b0}, 1'b1,
        '{ST_LOW, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_ACTIVATE, 16'd100, 10'h3FF, 1'b1}, 1'b1,
        '{ST_SHORT, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_ACTIVATE, 16'd100, 10'd0, 1'b0}, 1'b1,
        '{ST_LOW, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_ACTIVATE, 16'd0, 10'd900, 1'b0}, 1'b1,
        '{ST_FINISHED, 1'b0, 1'b0, 1'b0, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_TICK, 16'd0, 10'd500, 1'b1}, 1'b1,
        '{ST_NONE, 1'b0, 1'b0, 1'b1, DUR_CEIL_RST, 16'd0}},
      '{'{ACT_ACTIVATE, 16'd0, 10'd200, 1'b1}, 1'b0, '0},
      '{'{ACT_ACTIVATE, 16'd3, 10'd500, 1'b0}, 1'b0, '0},
      '{'{ACT_ACTIVATE, 16'd7, 10'd500, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd500, 1'b0}, 1'b0, '0},
      '{'{ACT_CLEAR, 16'd0, 10'd500, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd500, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd500, 1'b0}, 1'b0, '0},
      '{'{ACT_ACTIVATE, 16'hFFFF, 10'd600, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd600, 1'b1}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd600, 1'b1}, 1'b0, '0},
      '{'{ACT_ACTIVATE, 16'd2, 10'd600, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'h3FF, 1'b0}, 1'b0, '0},
      '{'{ACT_ACTIVATE, 16'd2, 10'd700, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd0, 1'b0}, 1'b0, '0},
      '{'{ACT_TICK, 16'd0, 10'd500, 1'b0}, 1'b0, '0}
   };

   pump_run_guard_adaptive_limit_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [STATUS_BITS-1:0] classify_level(input logic [SAMPLE_BITS-1:0] s);
      if (s > cfg_level_high) return ST_SHORT;
      if (s < cfg_level_low) return ST_LOW;
      return ST_NONE;
   endfunction

   // Floor first, ceiling last: the ceiling wins when the two cross
   function automatic logic [TICK_BITS-1:0] clamp_run_limit(input int unsigned v);
      if (v < cfg_floor) v = cfg_floor;
      if (v > cfg_ceiling) v = cfg_ceiling;
      return TICK_BITS'(v);
   endfunction

   function automatic rsp_item_type predict_pump_step(input req_item_type it);
      rsp_item_type         r;
      logic [STATUS_BITS-1:0] st;
      logic [STATUS_BITS-1:0] lv;
      logic [TICK_BITS-1:0]   run_len;
      int unsigned            trimmed;
      int unsigned            grown;
      st = ST_NONE;
      case (it.action)
         ACT_ACTIVATE: begin
            if (pump_running) begin
               st = ST_BUSY;
            end else begin
               st = classify_level(it.level_sample);
               if (st == ST_NONE) begin
                  // trim after an overflow, grow after a run that hit the limit
                  if (pump_overflow_seen) begin
                     trimmed = 32'(pump_last_run)
                             - ((32'(pump_last_run) + CUT_ROUND) >> CUT_SHIFT);
                     pump_limit = clamp_run_limit(trimmed);
                  end else if (pump_last_run == pump_limit) begin
                     grown = 32'(pump_limit) + (32'(pump_limit) >> GROW_SHIFT);
                     if (grown > TICK_MAX) grown = TICK_MAX;
                     pump_limit = clamp_run_limit(grown);
                  end
                  run_len = (it.requested_duration > pump_limit) ? pump_limit
                                                                 : it.requested_duration;
                  pump_overflow_seen = 1'b0;
                  pump_detect_armed  = 1'b1;
                  if (it.overflow_pin) begin
                     pump_overflow_seen = 1'b1;
                     pump_detect_armed  = 1'b0;
                     st = ST_OVERFLOW;
                  end else if (run_len == '0) begin
                     pump_elapsed  = '0;
                     pump_last_run = '0;
                     st = ST_FINISHED;
                  end else begin
                     pump_active  = 1'b1;
                     pump_running = 1'b1;
                     pump_elapsed = '0;
                     pump_target  = run_len;
                     st = ST_STARTED;
                  end
               end
            end
         end
         ACT_TICK: begin
            if (pump_running) begin
               if (pump_elapsed != '1) pump_elapsed = pump_elapsed + TICK_BITS'(1);
               lv = classify_level(it.level_sample);
               if (pump_detect_armed && it.overflow_pin) begin
                  pump_overflow_seen = 1'b1;
                  pump_detect_armed  = 1'b0;
                  st = ST_OVERFLOW;
               end else if (lv != ST_NONE) begin
                  st = lv;
               end else if (pump_elapsed >= pump_target) begin
                  st = ST_FINISHED;
               end
               // any stop reason ends the run
               if (st != ST_NONE) begin
                  pump_running  = 1'b0;
                  pump_active   = 1'b0;
                  pump_last_run = pump_elapsed;
               end
            end else if (pump_detect_armed && it.overflow_pin) begin
               pump_overflow_seen = 1'b1;
               pump_detect_armed  = 1'b0;
            end
         end
         ACT_CLEAR: begin
            pump_active = 1'b0;
         end
         default: begin
         end
      endcase
      r.status        = st;
      r.pump_on       = pump_running;
      r.active_mark   = pump_active;
      r.overflow_flag = pump_overflow_seen;
      r.run_limit     = pump_limit;
      r.last_run      = pump_last_run;
      return r;
   endfunction

   function automatic req_item_type make_beat(input logic [ACTION_BITS-1:0] action,
                                              input logic [TICK_BITS-1:0] duration,
                                              input logic [SAMPLE_BITS-1:0] sample,
                                              input logic pin);
      req_item_type it;
      it.action             = action;
      it.requested_duration = duration;
      it.level_sample       = sample;
      it.overflow_pin       = pin;
      return it;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] good_level();
      if (cfg_level_low <= cfg_level_high)
         return SAMPLE_BITS'($urandom_range(cfg_level_high, cfg_level_low));
      return SAMPLE_BITS'($urandom);
   endfunction

   // Mostly whole runs: activate, then ticks until the run ends, with rare disturbances
   function automatic req_item_type pick_random_beat();
      req_item_type it;
      int unsigned  roll;
      int unsigned  req_roll;
      roll = $urandom_range(0, 99);
      it = make_beat(ACT_TICK, TICK_BITS'($urandom_range(1, 24)), good_level(), 1'b0);
      if (roll < 2) begin
         // noise: any value of any field, unused action code included
         it.action             = ACTION_BITS'($urandom_range(0, 3));
         it.requested_duration = TICK_BITS'($urandom);
         it.level_sample       = SAMPLE_BITS'($urandom);
         it.overflow_pin       = 1'($urandom);
      end else if (!pump_running) begin
         if (roll < 75) begin
            it.action = ACT_ACTIVATE;
            req_roll = $urandom_range(0, 9);
            if (req_roll == 0)
               it.requested_duration = '0;
            else if (req_roll == 1 && pump_limit <= 200)
               it.requested_duration = TICK_BITS'($urandom);
            else if (req_roll < 6 && pump_limit <= 200)
               it.requested_duration = pump_limit + TICK_BITS'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) it.level_sample = SAMPLE_BITS'($urandom);
            it.overflow_pin = ($urandom_range(0, 19) == 0);
         end else if (roll < 90) begin
            it.overflow_pin = ($urandom_range(0, 3) == 0);
         end else begin
            it.action = ACT_CLEAR;
         end
      end else if (pump_elapsed > 300 || roll < 3) begin
         // cut long runs short through the armed overflow detector
         it.overflow_pin = 1'b1;
      end else if (roll < 5) begin
         it.level_sample = SAMPLE_BITS'($urandom);
      end else if (roll < 8) begin
         it.action = ACT_CLEAR;
      end else if (roll < 10) begin
         it.action = ACT_ACTIVATE;
      end
      return it;
   endfunction

   // Hand one beat to the block in bursts and gaps; predict it once accepted
   task automatic send_beat(input req_item_type it, input logic pinned,
                            input rsp_item_type want);
      rsp_item_type predicted;
      if (pacing_on && burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, it.overflow_pin, it.level_sample, it.requested_duration};
      req_tuser  <= it.action;
      do @(posedge clock); while (!req_tready);
      predicted = predict_pump_step(it);
      pending_results.push_back(pinned ? want : predicted);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_beat(pick_random_beat(), 1'b0, '0);
   endtask

   // Hold the sender until every outstanding result beat is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [TICK_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LEVEL_LOW:  cfg_level_low  = value[SAMPLE_BITS-1:0];
         CSR_LEVEL_HIGH: cfg_level_high = value[SAMPLE_BITS-1:0];
         CSR_DUR_FLOOR:  cfg_floor      = value;
         CSR_DUR_CEIL:   cfg_ceiling    = value;
         default: begin
         end
      endcase
   endtask

   task automatic set_thresholds(input logic [TICK_BITS-1:0] low, input logic [TICK_BITS-1:0] high,
                                 input logic [TICK_BITS-1:0] floor_v,
                                 input logic [TICK_BITS-1:0] ceil_v);
      drain();
      write_csr(CSR_LEVEL_LOW, low);
      write_csr(CSR_LEVEL_HIGH, high);
      write_csr(CSR_DUR_FLOOR, floor_v);
      write_csr(CSR_DUR_CEIL, ceil_v);
      csr_valid <= 1'b0;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         failure_count++;
         // limit log noise on a badly broken build
         if (failure_count <= LOG_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Receiver: switch between always ready, random and heavy stall modes
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_left <= $urandom_range(4, 40);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom);
         2: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            failure_count++;
            $display("%0t: result beat with nothing expected, expected none, got status %0d",
                     $time, rsp_tuser);
         end else begin
            wanted_beat = pending_results.pop_front();
            seen_beat.status        = rsp_tuser;
            seen_beat.pump_on       = rsp_tdata[0];
            seen_beat.active_mark   = rsp_tdata[1];
            seen_beat.overflow_flag = rsp_tdata[2];
            seen_beat.run_limit     = rsp_tdata[18:3];
            seen_beat.last_run      = rsp_tdata[34:19];
            compare_field("status", wanted_beat.status, seen_beat.status);
            compare_field("pump_on", wanted_beat.pump_on, seen_beat.pump_on);
            compare_field("active_mark", wanted_beat.active_mark, seen_beat.active_mark);
            compare_field("overflow_flag", wanted_beat.overflow_flag, seen_beat.overflow_flag);
            compare_field("run_limit", wanted_beat.run_limit, seen_beat.run_limit);
            compare_field("last_run", wanted_beat.last_run, seen_beat.last_run);
         end
      end
   end

   // Watchdog: end the run when no channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under the reset settings
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].want);

      // one run cut to a low floor, then grow the limit from a run that hit it
      set_thresholds(16'd0, 16'd1023, 16'd40, 16'hFFFF);
      pacing_on = 1'b0;
      send_beat(make_beat(ACT_ACTIVATE, 16'd10, 10'd512, 1'b1), 1'b0, '0);
      send_beat(make_beat(ACT_ACTIVATE, 16'hFFFF, 10'd512, 1'b0), 1'b0, '0);
      while (pump_running) send_beat(make_beat(ACT_TICK, 16'd0, 10'd512, 1'b0), 1'b0, '0);
      send_beat(make_beat(ACT_ACTIVATE, 16'd5, 10'd512, 1'b0), 1'b0, '0);
      while (pump_running) send_beat(make_beat(ACT_TICK, 16'd0, 10'd512, 1'b0), 1'b0, '0);
      pacing_on = 1'b1;

      // random phases over several settings, extremes first
      set_thresholds(16'hFC00, 16'hFFFF, 16'd1, 16'hFFFF);
      run_random(150);
      set_thresholds(16'd100, 16'd800, 16'd33, 16'd70);
      run_random(250);
      set_thresholds(16'h03FF, 16'h03FF, 16'd1, 16'd1);
      run_random(60);
      set_thresholds(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      run_random(50);
      set_thresholds(16'd300, 16'd700, 16'd500, 16'd40);
      run_random(150);
      repeat (3) begin
         set_thresholds(16'($urandom_range(0, 400)), 16'($urandom_range(600, 1023)),
                        16'($urandom_range(1, 60)), 16'($urandom_range(20, 120)));
         run_random(150);
      end

      drain();
      if (failure_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/prgal_pkg.sv
hw/rtl/pump_run_guard_adaptive_limit_core.sv
dv/tb_pump_run_guard_adaptive_limit_core.sv
